// ----- src/pps_pkg.sv -----
`timescale 1ns / 1ps
package pps_pkg;

  // Field widths
  localparam int SLOT_W  = 4;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ARR_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 5;

  // Default table depth and reset value of the process count register
  localparam int               MAX_SLOTS_DEF = 16;
  localparam logic [CNT_W-1:0] CNT_RESET     = CNT_W'(16);

  // Stream word widths (packed fields, padded to whole bytes)
  localparam int IN_FIELDS_W  = SLOT_W + BURST_W + PRIO_W + ARR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + 3 + 3 * TIME_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Input word kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Saturating count of busy slots seen so far in a scan
  localparam logic [1:0] BUSY_NONE = 2'd0;
  localparam logic [1:0] BUSY_ONE  = 2'd1;
  localparam logic [1:0] BUSY_MANY = 2'd2;

  // Slot contents written by a load word
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arr;
  } load_t;

  // Best candidate so far, handed from cell to cell
  typedef struct packed {
    logic               found;
    logic [1:0]         busy_cnt;
    logic               last;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
  } cand_t;

endpackage

// ----- src/pps_cell.sv -----
`timescale 1ns / 1ps
module pps_cell
  import pps_pkg::*;
#(
  parameter int               IDX_W    = 4,
  parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  load_t             wr_data,
  input  logic              step_en,
  input  logic              in_use,
  input  logic [TIME_W-1:0] time_now,
  input  logic              dec_en,
  input  cand_t             cand_in,
  input  logic [IDX_W-1:0]  idx_in,
  output cand_t             cand_out,
  output logic [IDX_W-1:0]  idx_out
);

  logic [BURST_W-1:0] rem_r, rem_nxt;
  logic [BURST_W-1:0] burst_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [ARR_W-1:0]   arr_r;
  cand_t              cand_r, cand_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic busy, arrived, ready, take;

  // Slot status
  assign busy    = in_use && (rem_r != '0);
  assign arrived = (time_now[TIME_W-1:ARR_W] != '0) || (arr_r <= time_now[ARR_W-1:0]);
  assign ready   = busy && arrived;
  assign take    = ready && (!cand_in.found || (prio_r < cand_in.prio));

  // Merge this slot into the incoming candidate
  always_comb begin
    cand_nxt       = cand_in;
    idx_nxt        = idx_in;
    cand_nxt.found = cand_in.found || ready;
    if (cand_in.busy_cnt == BUSY_MANY) begin
      cand_nxt.busy_cnt = BUSY_MANY;
    end else if (busy) begin
      cand_nxt.busy_cnt = cand_in.busy_cnt + 2'd1;
    end
    if (take) begin
      cand_nxt.last  = (rem_r == BURST_W'(1));
      cand_nxt.prio  = prio_r;
      cand_nxt.arr   = arr_r;
      cand_nxt.burst = burst_r;
      idx_nxt        = CELL_IDX;
    end
  end

  // Remaining time: load restarts, commit counts down
  always_comb begin
    rem_nxt = rem_r;
    if (wr_en) begin
      rem_nxt = wr_data.burst;
    end else if (dec_en) begin
      rem_nxt = rem_r - BURST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  // Slot table entry and candidate stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      burst_r <= wr_data.burst;
      prio_r  <= wr_data.prio;
      arr_r   <= wr_data.arr;
    end
    if (step_en) begin
      cand_r <= cand_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign cand_out = cand_r;
  assign idx_out  = idx_r;

endmodule

// ----- src/preemptive_priority_scheduler_top.sv -----
`timescale 1ns / 1ps
// Preemptive priority scheduler.
// in_*  : input words. in_tuser is the kind (0 load a slot, 1 time tick).
//         A load writes burst, priority and arrival of one slot and restarts it;
//         it gives no result.
// out_* : one result word per tick: the slot that ran, busy/finished flags,
//         finish time, turnaround, waiting time and the all-done flag.
// cfg_* : writes process_count (slots in use, scanned from slot zero); write only
//         while no tick is in flight.
// A tick walks a candidate down a row of MAX_SLOTS slot cells, one cell per
// cycle, then passes the commit, turnaround and finish states to commit the run
// and form the timing fields. No new word is taken until the result has been
// loaded into the output register. The scan length sets the rate.
// A finished result waits in the output register; loads are still taken while
// it waits, and a following tick scans but holds its result until the register
// frees. Reset empties all slots (no work pending), clears time to zero and sets
// process_count to 16. Slot table contents are undefined until loaded.
module preemptive_priority_scheduler_top
  import pps_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // slot, burst_len, prio_level, arrive_time
  input  logic                  in_tuser,   // action
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // ran_slot, busy_res, finished, finish_time,
                                            // turnaround, waiting, all_done
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(MAX_SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_COMM = 3'd2;
  localparam logic [2:0] ST_TAT  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    step_r, step_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [TIME_W-1:0]   tat_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [SLOT_W-1:0]   in_slot;
  load_t               in_load;
  logic                in_acc, load_acc, tick_acc;

  cand_t               cand_w [MAX_SLOTS+1];
  logic [IDX_W-1:0]    idx_w  [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0] wr_vec, step_vec, use_vec, dec_vec;

  cand_t               fin_c;
  logic [IDX_W-1:0]    fin_idx;
  logic                finished, all_done, out_load;
  logic [TIME_W-1:0]   wait_val, ft_val, tat_val;

  // Input word unpacking
  assign in_slot       = in_tdata[SLOT_W-1:0];
  assign in_load.burst = in_tdata[SLOT_W +: BURST_W];
  assign in_load.prio  = in_tdata[SLOT_W+BURST_W +: PRIO_W];
  assign in_load.arr   = in_tdata[SLOT_W+BURST_W+PRIO_W +: ARR_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser == ACT_LOAD);
  assign tick_acc  = in_acc && (in_tuser == ACT_TICK);

  // Empty candidate enters the first cell
  assign cand_w[0] = '0;
  assign idx_w[0]  = '0;

  // Row of slot cells
  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
    assign wr_vec[k]   = load_acc && (32'(in_slot) == 32'(k));
    assign step_vec[k] = (state_r == ST_SCAN) && (step_r == IDX_W'(k));
    assign use_vec[k]  = (32'(k) < 32'(cnt_r));
    assign dec_vec[k]  = (state_r == ST_COMM) && fin_c.found && (fin_idx == IDX_W'(k));

    pps_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (IDX_W'(k))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_vec[k]),
      .wr_data  (in_load),
      .step_en  (step_vec[k]),
      .in_use   (use_vec[k]),
      .time_now (time_r),
      .dec_en   (dec_vec[k]),
      .cand_in  (cand_w[k]),
      .idx_in   (idx_w[k]),
      .cand_out (cand_w[k+1]),
      .idx_out  (idx_w[k+1])
    );
  end

  assign fin_c   = cand_w[MAX_SLOTS];
  assign fin_idx = idx_w[MAX_SLOTS];

  // Result fields
  assign finished = fin_c.found && fin_c.last;
  assign all_done = fin_c.found ? (fin_c.last && (fin_c.busy_cnt == BUSY_ONE))
                                : (fin_c.busy_cnt == BUSY_NONE);
  assign wait_val = (tat_r >= TIME_W'(fin_c.burst)) ? tat_r - TIME_W'(fin_c.burst) : '0;
  assign ft_val   = finished ? time_r : '0;
  assign tat_val  = finished ? tat_r : '0;

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    time_nxt  = time_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = ST_SCAN;
          step_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (step_r == IDX_W'(MAX_SLOTS - 1)) begin
          state_nxt = ST_COMM;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      ST_COMM: begin
        if (time_r != '1) begin
          time_nxt = time_r + TIME_W'(1);
        end
        state_nxt = ST_TAT;
      end
      ST_TAT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      time_r      <= '0;
      cnt_r       <= CNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cnt_r <= cfg_data;
      end
    end
  end

  // Turnaround and result word
  always_ff @(posedge clk) begin
    if (state_r == ST_TAT) begin
      tat_r <= (time_r >= TIME_W'(fin_c.arr)) ? time_r - TIME_W'(fin_c.arr) : '0;
    end
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({all_done,
                                 finished ? wait_val : TIME_W'(0),
                                 tat_val,
                                 ft_val,
                                 finished,
                                 fin_c.found,
                                 fin_c.found ? SLOT_W'(fin_idx) : SLOT_W'(0)});
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
